>>> hw/rtl/cau_pkg.sv
package cau_pkg;

  localparam int DataW = 32;
  localparam int FracW = 16;
  localparam int ProdW = 2 * DataW;
  localparam int SumW  = ProdW + 1;
  localparam int RemW  = SumW + FracW;
  localparam int QW    = DataW;
  localparam int DshW  = ProdW + DataW - 1;
  localparam int CmpW  = ProdW + DataW;
  // front stages: product, sum, magnitude, divide setup; then one stage per
  // quotient bit; then the output register
  localparam int NumStages = 5 + QW;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DIV0 = 2'd1,
    ST_SAT  = 2'd2
  } status_e;

  typedef struct packed {
    op_e                      op;
    logic                     zero;
    logic signed [ProdW-1:0]  rr;
    logic signed [ProdW-1:0]  ii;
    logic signed [ProdW-1:0]  ri;
    logic signed [ProdW-1:0]  ir;
    logic        [ProdW-1:0]  bb;
    logic        [ProdW-1:0]  cc;
    logic signed [DataW:0]    s_re;
    logic signed [DataW:0]    s_im;
  } prod_t;

  typedef struct packed {
    op_e                     op;
    logic                    zero;
    logic signed [SumW-1:0]  re;
    logic signed [SumW-1:0]  im;
    logic        [ProdW-1:0] den;
  } sum_t;

  typedef struct packed {
    op_e              op;
    logic             zero;
    logic             neg_re;
    logic             neg_im;
    logic [SumW-1:0]  mre;
    logic [SumW-1:0]  mim;
    logic [ProdW-1:0] den;
  } mag_t;

  typedef struct packed {
    op_e             op;
    logic            zero;
    logic            neg_re;
    logic            neg_im;
    logic            ovf_re;
    logic            ovf_im;
    logic [RemW-1:0] rem_re;
    logic [RemW-1:0] rem_im;
    logic [DshW-1:0] dsh;
    logic [QW-1:0]   q_re;
    logic [QW-1:0]   q_im;
  } div_t;

  // Saturate a sign and magnitude to the signed data range; MSB is the flag.
  function automatic logic [DataW:0] sat_fn(input logic neg, input logic [SumW-1:0] m);
    logic [SumW-1:0]  lim;
    logic [DataW-1:0] v;
    logic             flag;
    lim  = SumW'(1) << (DataW - 1);
    flag = (m > lim) || ((m == lim) && !neg);
    if (flag) begin
      v = neg ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
    end else begin
      v = neg ? (~m[DataW-1:0] + DataW'(1)) : m[DataW-1:0];
    end
    return {flag, v};
  endfunction

endpackage

>>> hw/rtl/cau_mult.sv
module cau_mult import cau_pkg::*; (
  input  logic                    clk_i,
  input  logic                    en_a_i,
  input  logic                    en_b_i,
  input  op_e                     op_i,
  input  logic signed [DataW-1:0] ar_i,
  input  logic signed [DataW-1:0] ai_i,
  input  logic signed [DataW-1:0] br_i,
  input  logic signed [DataW-1:0] bi_i,
  output sum_t                    sum_o
);

  prod_t prod_d, prod_q;
  sum_t  sum_d, sum_q;
  logic signed [ProdW-1:0] bb_s, cc_s;

  // form all partial products and the plain sums
  always_comb begin
    bb_s         = br_i * br_i;
    cc_s         = bi_i * bi_i;
    prod_d.op    = op_i;
    prod_d.zero  = (br_i == '0) && (bi_i == '0);
    prod_d.rr    = ar_i * br_i;
    prod_d.ii    = ai_i * bi_i;
    prod_d.ri    = ar_i * bi_i;
    prod_d.ir    = ai_i * br_i;
    prod_d.bb    = $unsigned(bb_s);
    prod_d.cc    = $unsigned(cc_s);
    if (op_i == OP_SUB) begin
      prod_d.s_re = (DataW+1)'(ar_i) - (DataW+1)'(br_i);
      prod_d.s_im = (DataW+1)'(ai_i) - (DataW+1)'(bi_i);
    end else begin
      prod_d.s_re = (DataW+1)'(ar_i) + (DataW+1)'(br_i);
      prod_d.s_im = (DataW+1)'(ai_i) + (DataW+1)'(bi_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a_i) begin
      prod_q <= prod_d;
    end
  end

  // combine products per operation
  always_comb begin
    sum_d.op   = prod_q.op;
    sum_d.zero = prod_q.zero;
    sum_d.den  = prod_q.bb + prod_q.cc;
    case (prod_q.op)
      OP_MUL: begin
        sum_d.re = SumW'(prod_q.rr) - SumW'(prod_q.ii);
        sum_d.im = SumW'(prod_q.ri) + SumW'(prod_q.ir);
      end
      OP_DIV: begin
        sum_d.re = SumW'(prod_q.rr) + SumW'(prod_q.ii);
        sum_d.im = SumW'(prod_q.ir) - SumW'(prod_q.ri);
      end
      default: begin
        sum_d.re = SumW'(prod_q.s_re);
        sum_d.im = SumW'(prod_q.s_im);
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_b_i) begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

>>> hw/rtl/cau_prep.sv
module cau_prep import cau_pkg::*; (
  input  logic clk_i,
  input  logic en_c_i,
  input  logic en_d_i,
  input  sum_t sum_i,
  output div_t div_o
);

  mag_t mag_d, mag_q;
  div_t div_d, div_q;
  logic [RemW-1:0] num_re, num_im;

  // split into sign and magnitude
  always_comb begin
    mag_d.op     = sum_i.op;
    mag_d.zero   = sum_i.zero;
    mag_d.den    = sum_i.den;
    mag_d.neg_re = sum_i.re[SumW-1];
    mag_d.neg_im = sum_i.im[SumW-1];
    mag_d.mre    = sum_i.re[SumW-1] ? $unsigned(-sum_i.re) : $unsigned(sum_i.re);
    mag_d.mim    = sum_i.im[SumW-1] ? $unsigned(-sum_i.im) : $unsigned(sum_i.im);
  end

  always_ff @(posedge clk_i) begin
    if (en_c_i) begin
      mag_q <= mag_d;
    end
  end

  // scale numerators for divide or products for multiply, detect quotients too wide, align the divisor
  always_comb begin
    num_re        = RemW'(mag_q.mre) << FracW;
    num_im        = RemW'(mag_q.mim) << FracW;
    div_d.op      = mag_q.op;
    div_d.zero    = mag_q.zero;
    div_d.neg_re  = mag_q.neg_re;
    div_d.neg_im  = mag_q.neg_im;
    div_d.dsh     = DshW'(mag_q.den) << (DataW - 1);
    div_d.q_re    = '0;
    div_d.q_im    = '0;
    div_d.ovf_re  = 1'b0;
    div_d.ovf_im  = 1'b0;
    case (mag_q.op)
      OP_DIV: begin
        div_d.rem_re = num_re;
        div_d.rem_im = num_im;
        div_d.ovf_re = CmpW'(num_re) >= {mag_q.den, {DataW{1'b0}}};
        div_d.ovf_im = CmpW'(num_im) >= {mag_q.den, {DataW{1'b0}}};
      end
      OP_MUL: begin
        div_d.rem_re = RemW'(mag_q.mre >> FracW);
        div_d.rem_im = RemW'(mag_q.mim >> FracW);
      end
      default: begin
        div_d.rem_re = RemW'(mag_q.mre);
        div_d.rem_im = RemW'(mag_q.mim);
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_d_i) begin
      div_q <= div_d;
    end
  end

  assign div_o = div_q;

endmodule

>>> hw/rtl/cau_div_step.sv
module cau_div_step import cau_pkg::*; (
  input  logic clk_i,
  input  logic en_i,
  input  div_t div_i,
  output div_t div_o
);

  div_t div_d, div_q;
  logic take_re, take_im;

  // one restoring step for each part; other operations pass through
  always_comb begin
    take_re = (div_i.op == OP_DIV) && (DshW'(div_i.rem_re) >= div_i.dsh);
    take_im = (div_i.op == OP_DIV) && (DshW'(div_i.rem_im) >= div_i.dsh);
    div_d        = div_i;
    div_d.dsh    = div_i.dsh >> 1;
    div_d.q_re   = {div_i.q_re[QW-2:0], take_re};
    div_d.q_im   = {div_i.q_im[QW-2:0], take_im};
    if (take_re) begin
      div_d.rem_re = RemW'(DshW'(div_i.rem_re) - div_i.dsh);
    end
    if (take_im) begin
      div_d.rem_im = RemW'(DshW'(div_i.rem_im) - div_i.dsh);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q <= div_d;
    end
  end

  assign div_o = div_q;

endmodule

>>> hw/rtl/cau_sat.sv
module cau_sat import cau_pkg::*; (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  div_t                    div_i,
  output logic signed [DataW-1:0] re_o,
  output logic signed [DataW-1:0] im_o,
  output status_e                 status_o
);

  logic [SumW-1:0] m_re, m_im;
  logic [DataW:0]  s_re, s_im;
  logic [DataW-1:0] re_d, re_q, im_d, im_q;
  status_e st_d, st_q;

  // pick the final magnitude and clamp it
  always_comb begin
    if (div_i.op == OP_DIV) begin
      m_re = div_i.ovf_re ? (SumW'(1) << DataW) : SumW'(div_i.q_re);
      m_im = div_i.ovf_im ? (SumW'(1) << DataW) : SumW'(div_i.q_im);
    end else begin
      m_re = div_i.rem_re[SumW-1:0];
      m_im = div_i.rem_im[SumW-1:0];
    end
    s_re = sat_fn(div_i.neg_re, m_re);
    s_im = sat_fn(div_i.neg_im, m_im);
    if ((div_i.op == OP_DIV) && div_i.zero) begin
      re_d = '0;
      im_d = '0;
      st_d = ST_DIV0;
    end else begin
      re_d = s_re[DataW-1:0];
      im_d = s_im[DataW-1:0];
      st_d = (s_re[DataW] || s_im[DataW]) ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      re_q <= re_d;
      im_q <= im_d;
      st_q <= st_d;
    end
  end

  assign re_o     = $signed(re_q);
  assign im_o     = $signed(im_q);
  assign status_o = st_q;

endmodule

>>> hw/rtl/complex_arithmetic_unit.sv
// Complex add, subtract, multiply and divide on Q16.16 operands. The block
// takes one beat per cycle unless stall_o is high and returns one result beat
// per input beat, in order, through its pipeline: four front stages
// (products, sums, sign split, divider setup), one stage per quotient bit of
// the 32-bit divider, and the output register. Every stage holds its own
// beat, so a stalled output only backs up the pipeline as far as it is full.
// Results that fall outside the 32-bit range clamp and report saturation; a
// zero divisor gives zero results and a divide-by-zero status.
module complex_arithmetic_unit import cau_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    stall_o,
  input  logic [1:0]              operation_i,
  input  logic signed [DataW-1:0] a_real_i,
  input  logic signed [DataW-1:0] a_imag_i,
  input  logic signed [DataW-1:0] b_real_i,
  input  logic signed [DataW-1:0] b_imag_i,
  output logic                    valid_o,
  input  logic                    stall_i,
  output logic signed [DataW-1:0] result_real_o,
  output logic signed [DataW-1:0] result_imag_o,
  output logic [1:0]              status_o
);

  logic [NumStages-1:0] v_q, v_d, rdy;
  sum_t    sum_w;
  div_t    div_w [QW+1];
  status_e st_w;

  // stage ready chain: a stage loads when empty or when its successor loads
  always_comb begin
    rdy[NumStages-1] = !v_q[NumStages-1] || !stall_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
    v_d[0] = rdy[0] ? valid_i : v_q[0];
    for (int k = 1; k < NumStages; k++) begin
      if (rdy[k]) begin
        v_d[k] = v_q[k-1];
      end else begin
        v_d[k] = v_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign stall_o = !rdy[0];
  assign valid_o = v_q[NumStages-1];

  cau_mult u_mult (
    .clk_i  (clk_i),
    .en_a_i (rdy[0]),
    .en_b_i (rdy[1]),
    .op_i   (op_e'(operation_i)),
    .ar_i   (a_real_i),
    .ai_i   (a_imag_i),
    .br_i   (b_real_i),
    .bi_i   (b_imag_i),
    .sum_o  (sum_w)
  );

  cau_prep u_prep (
    .clk_i  (clk_i),
    .en_c_i (rdy[2]),
    .en_d_i (rdy[3]),
    .sum_i  (sum_w),
    .div_o  (div_w[0])
  );

  // one quotient bit per stage
  for (genvar g = 0; g < QW; g++) begin : g_step
    cau_div_step u_step (
      .clk_i (clk_i),
      .en_i  (rdy[4+g]),
      .div_i (div_w[g]),
      .div_o (div_w[g+1])
    );
  end

  cau_sat u_sat (
    .clk_i    (clk_i),
    .en_i     (rdy[NumStages-1]),
    .div_i    (div_w[QW]),
    .re_o     (result_real_o),
    .im_o     (result_imag_o),
    .status_o (st_w)
  );

  assign status_o = st_w;

endmodule

>>> hw/rtl/cau_checker.sv
module cau_checker import cau_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    stall_o,
  input logic                    valid_o,
  input logic                    stall_i,
  input logic signed [DataW-1:0] result_real_o,
  input logic signed [DataW-1:0] result_imag_o,
  input logic [1:0]              status_o
);

  // hold a stalled output beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(result_real_o) && $stable(result_imag_o)
      && $stable(status_o))
    else $error("stalled output beat changed");

  // backpressure reaches the input only with the whole pipeline full and stalled
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> valid_o && stall_i)
    else $error("input stalled without output stall");

  // divide by zero returns zero parts
  a_div0_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (status_o == ST_DIV0) |-> (result_real_o == '0) && (result_imag_o == '0))
    else $error("divide by zero with nonzero result");

  // no undefined status code
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (status_o == ST_OK) || (status_o == ST_DIV0) || (status_o == ST_SAT))
    else $error("undefined status code");

  // no output beat right after reset
  a_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !valid_o)
    else $error("output beat out of reset");

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .stall_o       (stall_o),
  .valid_o       (valid_o),
  .stall_i       (stall_i),
  .result_real_o (result_real_o),
  .result_imag_o (result_imag_o),
  .status_o      (status_o)
);

>>> dv/tb_complex_arithmetic_unit.sv
`timescale 1ns / 100ps

module tb_complex_arithmetic_unit;
  import cau_pkg::*;

  localparam int CycleLimit = 400000;

  typedef struct {
    logic signed [DataW-1:0] re;
    logic signed [DataW-1:0] im;
    status_e                 st;
  } cplx_res_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    valid_i = 1'b0;
  logic                    stall_o;
  logic [1:0]              operation_i = OP_ADD;
  logic signed [DataW-1:0] a_real_i = '0;
  logic signed [DataW-1:0] a_imag_i = '0;
  logic signed [DataW-1:0] b_real_i = '0;
  logic signed [DataW-1:0] b_imag_i = '0;
  logic                    valid_o;
  logic                    stall_i = 1'b0;
  logic signed [DataW-1:0] result_real_o;
  logic signed [DataW-1:0] result_imag_o;
  logic [1:0]              status_o;

  cplx_res_t pending_q[$];
  int        n_errors = 0;
  int        cycle_cnt = 0;
  bit        send_gaps = 1'b1;
  bit        recv_gaps = 1'b1;
  int        hold_cycles = 0;

  complex_arithmetic_unit uut (.*);

  always #5 clk_i = ~clk_i;

  // Clamp a wide signed value to the data range; flag when clamped.
  function automatic logic signed [DataW-1:0] clamp_part(input logic signed [191:0] v,
                                                        output bit sat);
    logic signed [191:0] hi, lo;
    hi = 192'sd2147483647;
    lo = -192'sd2147483648;
    sat = 1'b1;
    if (v > hi) return hi[DataW-1:0];
    if (v < lo) return lo[DataW-1:0];
    sat = 1'b0;
    return v[DataW-1:0];
  endfunction

  // Compute the expected complex result of one operation.
  function automatic cplx_res_t complex_result(input op_e op,
      input logic signed [DataW-1:0] ar, ai, br, bi);
    logic signed [191:0] xr, xi, yr, yi, re, im, den;
    cplx_res_t r;
    bit s1, s2;
    xr = ar; xi = ai; yr = br; yi = bi;
    case (op)
      OP_ADD: begin re = xr + yr; im = xi + yi; end
      OP_SUB: begin re = xr - yr; im = xi - yi; end
      OP_MUL: begin
        re = xr * yr - xi * yi;
        im = xr * yi + xi * yr;
        // truncate toward zero
        re = re / (192'sd1 <<< FracW);
        im = im / (192'sd1 <<< FracW);
      end
      default: begin
        den = yr * yr + yi * yi;
        if (den == 0) begin
          r.re = '0; r.im = '0; r.st = ST_DIV0;
          return r;
        end
        re = ((xr * yr + xi * yi) * (192'sd1 <<< FracW)) / den;
        im = ((xi * yr - xr * yi) * (192'sd1 <<< FracW)) / den;
      end
    endcase
    r.re = clamp_part(re, s1);
    r.im = clamp_part(im, s2);
    r.st = (s1 || s2) ? ST_SAT : ST_OK;
    return r;
  endfunction

  // Offer one beat, hold it until accepted, and queue its expectation.
  task automatic send_beat(input op_e op, input logic [DataW-1:0] ar, ai, br, bi);
    while (send_gaps && $urandom_range(99) < 24) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i     <= 1'b1;
    operation_i <= op;
    a_real_i    <= ar;
    a_imag_i    <= ai;
    b_real_i    <= br;
    b_imag_i    <= bi;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
    pending_q.push_back(complex_result(op, ar, ai, br, bi));
  endtask

  function automatic logic [DataW-1:0] rand_operand();
    case ($urandom_range(5))
      0: return {DataW{1'b0}};
      1: return 32'h8000_0000;
      2: return 32'h7fff_ffff;
      3: return $urandom_range(32'h0003_0000) - 32'h0001_8000;
      4: return {{12{$urandom_range(1) == 1}}, 20'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  task automatic wait_drained();
    valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    logic [DataW-1:0] mx, mn, one;
    mx = 32'h7fff_ffff; mn = 32'h8000_0000; one = 32'h0001_0000;
    for (int k = 0; k < 4; k++) begin
      send_beat(op_e'(k), mx, mn, mx, mn);
      send_beat(op_e'(k), mn, mn, mn, mn);
      send_beat(op_e'(k), one, -one, 32'h0002_8000, one);
      send_beat(op_e'(k), 32'hffff_ffff, 32'h0, 32'h1, 32'hffff_ffff);
    end
    send_beat(OP_DIV, mx, mx, 32'h0, 32'h0);
    send_beat(OP_DIV, one, one, 32'h1, 32'h0);
    send_beat(OP_DIV, mn, 32'h0, 32'h0, 32'hffff_ffff);
    send_beat(OP_MUL, mx, mx, mx, mx);
    send_beat(OP_ADD, 32'h4000_0000, 32'h0, 32'h4000_0000, 32'h0);
    send_beat(OP_SUB, mn, mx, 32'h1, 32'hffff_ffff);
  endtask

  task automatic test_random(input int n);
    for (int k = 0; k < n; k++)
      send_beat(op_e'($urandom_range(3)), rand_operand(), rand_operand(),
                rand_operand(), rand_operand());
  endtask

  // Stall the output for a long stretch so the pipeline fills.
  task automatic test_backpressure();
    hold_cycles = 120;
    test_random(80);
    wait_drained();
  endtask

  task automatic test_no_gaps();
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    test_random(150);
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
  endtask

  // Drive the receiver stall at random, or hold it for a counted stretch.
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      stall_i     <= 1'b1;
    end else begin
      stall_i <= recv_gaps && ($urandom_range(99) < 24);
    end
  end

  // Compare each result beat with the oldest expectation.
  always @(posedge clk_i) begin
    cplx_res_t e;
    if (rst_ni && valid_o && !stall_i) begin
      if (pending_q.size() == 0) begin
        $error("unexpected result beat");
        n_errors++;
      end else begin
        e = pending_q.pop_front();
        if (result_real_o !== e.re) begin
          $error("result_real exp %0d got %0d", e.re, result_real_o);
          n_errors++;
        end
        if (result_imag_o !== e.im) begin
          $error("result_imag exp %0d got %0d", e.im, result_imag_o);
          n_errors++;
        end
        if (status_o !== e.st) begin
          $error("status exp %0d got %0d", e.st, status_o);
          n_errors++;
        end
      end
    end
  end

  // Abort on a hang.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    wait_drained();
    test_random(250);
    test_backpressure();
    test_no_gaps();
    test_random(200);
    wait_drained();
    repeat (3 * NumStages) @(posedge clk_i);
    if (n_errors == 0 && pending_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
